### src/x86_instruction_length_decoder_defines.svh
// Assertion macros for the x86 instruction length decoder.
// Used by the top level; needs a clock named i_clk and reset i_rst_n in scope.
`ifndef X86_INSTRUCTION_LENGTH_DECODER_DEFINES_SVH
`define X86_INSTRUCTION_LENGTH_DECODER_DEFINES_SVH

// same-cycle implication
`define ILD_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define ILD_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### src/x86ild_pkg.sv
// Shared types, codes and opcode tables for the x86 instruction length decoder.
// No dependencies.
package x86ild_pkg;

    localparam int OFFSET_BITS = 32;

    localparam logic [1:0] KIND_PREFIX = 2'd0;
    localparam logic [1:0] KIND_ESCAPE = 2'd1;
    localparam logic [1:0] KIND_INSN   = 2'd2;
    localparam logic [1:0] KIND_ERROR  = 2'd3;

    localparam logic [3:0] MAX_PREFIXES_RST = 4'd4;

    typedef enum logic [5:0] {
        PH_OPCODE   = 6'b000001,
        PH_ESCAPE   = 6'b000010,
        PH_MODRM    = 6'b000100,
        PH_SIB      = 6'b001000,
        PH_SIB_MOD0 = 6'b010000,
        PH_TAIL     = 6'b100000
    } t_phase;

    function automatic logic is_prefix(input logic [7:0] b);
        logic res;
        begin
            case (b) inside
                8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65,
                8'h66, 8'h67, 8'hF0, 8'hF2, 8'hF3, 8'h0F: res = 1'b1;
                default: res = 1'b0;
            endcase
            return res;
        end
    endfunction

    function automatic logic takes_modrm(input logic [7:0] op);
        logic res;
        begin
            if (op < 8'h40) begin
                res = (op[2:0] < 3'd4);
            end else begin
                case (op) inside
                    [8'h80:8'h8F], [8'hC4:8'hC7], [8'hD0:8'hD3], [8'hD8:8'hDF],
                    8'h62, 8'h63, 8'h69, 8'h6B, 8'hC0, 8'hC1,
                    8'hF6, 8'hF7, 8'hFE, 8'hFF: res = 1'b1;
                    default: res = 1'b0;
                endcase
            end
            return res;
        end
    endfunction

    // immediate bytes; osz shrinks Iz to a word
    function automatic logic [2:0] imm_bytes(input logic [7:0] op, input logic osz);
        logic [2:0] iz;
        logic [2:0] res;
        begin
            iz = osz ? 3'd2 : 3'd4;
            if (op < 8'h40) begin
                if (op[2:0] == 3'd4) begin
                    res = 3'd1;
                end else if (op[2:0] == 3'd5) begin
                    res = iz;
                end else begin
                    res = 3'd0;
                end
            end else begin
                case (op) inside
                    [8'h70:8'h7F], [8'hB0:8'hB7], [8'hE0:8'hE7],
                    8'h6A, 8'h6B, 8'h80, 8'h82, 8'h83, 8'hA8, 8'hC0, 8'hC1,
                    8'hC6, 8'hCD, 8'hD4, 8'hD5, 8'hEB: res = 3'd1;
                    [8'hA0:8'hA3]: res = 3'd4;
                    [8'hB8:8'hBF],
                    8'h68, 8'h69, 8'h81, 8'hA9, 8'hC7, 8'hE8, 8'hE9: res = iz;
                    8'hC2, 8'hCA: res = 3'd2;
                    8'hC8: res = 3'd3;
                    8'h9A, 8'hEA: res = iz + 3'd2;
                    default: res = 3'd0;
                endcase
            end
            return res;
        end
    endfunction

endpackage

### src/x86_instruction_length_decoder.sv
// x86 instruction length decoder top level: byte-serial length decode.
// Depends on x86ild_pkg and x86_instruction_length_decoder_defines.svh.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+-------------------------------------------
//  in       | i_in_valid / o_in_ready  | i_code_byte, i_restart
//  out      | o_out_valid / i_out_ready| o_unit_length .. o_running_offset
//  cfg      | i_cfg_we                 | i_cfg_data (max_prefixes)
//
// One code byte per cycle while the output is not stalled; a unit is reported in the cycle after its last byte.
// Decode state and the byte's result come from one pass of logic into the
// state and output registers. A full output register that is not being taken
// stalls the input. Synchronous active-low reset; no clearing pass.
`include "x86_instruction_length_decoder_defines.svh"

module x86_instruction_length_decoder
    import x86ild_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_code_byte,
    input  logic        i_restart,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [3:0]  o_unit_length,
    output logic [1:0]  o_unit_kind,
    output logic [7:0]  o_opcode_value,
    output logic        o_has_modrm,
    output logic [3:0]  o_operand_bytes,
    output logic [3:0]  o_prefixes_before,
    output logic [31:0] o_running_offset
);

    logic [3:0]             r_max_prefixes;
    t_phase                 r_phase, n_phase, cur_phase;
    logic [3:0]             r_bytes_left, n_bytes_left;
    logic [2:0]             r_imm, n_imm;
    logic [3:0]             r_unit_count, n_unit_count;
    logic [3:0]             r_tally, n_tally, cur_tally;
    logic                   r_osz, n_osz, cur_osz;
    logic [7:0]             r_held, n_held;
    logic                   r_modrm_seen, n_modrm_seen;
    logic                   r_sib_seen, n_sib_seen;
    logic [OFFSET_BITS-1:0] r_offset, n_offset;

    logic                   r_out_valid;
    logic [3:0]             r_len;
    logic [1:0]             r_kind;
    logic [7:0]             r_op;
    logic                   r_mr;
    logic [3:0]             r_opb;
    logic [3:0]             r_pb;
    logic [31:0]            r_out_offset;

    logic                   in_fire;
    logic                   emit, hdr, fin;
    logic [2:0]             hdr_disp;
    logic [3:0]             hdr_total;
    logic [3:0]             e_len;
    logic [1:0]             e_kind;
    logic [7:0]             e_op;
    logic                   e_mr;
    logic [3:0]             e_opb;
    logic [3:0]             e_pb;
    logic [1:0]             mr_mod;
    logic [2:0]             mr_reg, mr_rm;

    assign o_in_ready = !r_out_valid || i_out_ready;
    assign in_fire    = i_in_valid && o_in_ready;

    assign mr_mod = i_code_byte[7:6];
    assign mr_reg = i_code_byte[5:3];
    assign mr_rm  = i_code_byte[2:0];

    always_comb begin
        cur_phase    = i_restart ? PH_OPCODE : r_phase;
        cur_tally    = i_restart ? 4'd0 : r_tally;
        cur_osz      = i_restart ? 1'b0 : r_osz;
        n_offset     = (i_restart ? '0 : r_offset) + OFFSET_BITS'(1);
        n_phase      = cur_phase;
        n_tally      = cur_tally;
        n_osz        = cur_osz;
        n_bytes_left = r_bytes_left;
        n_imm        = r_imm;
        n_unit_count = r_unit_count;
        n_held       = r_held;
        n_modrm_seen = r_modrm_seen;
        n_sib_seen   = r_sib_seen;
        emit         = 1'b0;
        hdr          = 1'b0;
        fin          = 1'b0;
        hdr_disp     = 3'd0;
        hdr_total    = 4'd0;
        e_len        = 4'd1;
        e_kind       = KIND_PREFIX;
        e_op         = i_code_byte;
        e_mr         = 1'b0;
        e_opb        = 4'd0;
        e_pb         = cur_tally;

        unique case (cur_phase)
            PH_ESCAPE: begin
                n_phase = PH_OPCODE;
                emit    = 1'b1;
                e_len   = 4'd2;
                e_kind  = KIND_ESCAPE;
                e_pb    = cur_tally - 4'd1;
            end
            PH_MODRM: begin
                n_unit_count = r_unit_count + 4'd1;
                n_modrm_seen = 1'b1;
                if ((r_held == 8'hF6 || r_held == 8'hF7) && mr_reg == 3'd0) begin
                    n_imm = (r_held == 8'hF6) ? 3'd1 : (cur_osz ? 3'd2 : 3'd4);
                end
                case (mr_mod)
                    2'd1:    hdr_disp = 3'd1;
                    2'd2:    hdr_disp = 3'd4;
                    2'd3:    hdr_disp = 3'd0;
                    default: hdr_disp = (mr_rm == 3'd5) ? 3'd4 : 3'd0;
                endcase
                if (mr_mod != 2'd3 && mr_rm == 3'd4) begin
                    n_bytes_left = {1'b0, hdr_disp};
                    n_phase      = (mr_mod == 2'd0) ? PH_SIB_MOD0 : PH_SIB;
                end else begin
                    hdr = 1'b1;
                end
            end
            PH_SIB, PH_SIB_MOD0: begin
                n_unit_count = r_unit_count + 4'd1;
                n_sib_seen   = 1'b1;
                hdr          = 1'b1;
                if (cur_phase == PH_SIB_MOD0 && i_code_byte[2:0] == 3'd5) begin
                    hdr_disp = 3'd4;
                end else begin
                    hdr_disp = r_bytes_left[2:0];
                end
            end
            PH_TAIL: begin
                n_unit_count = r_unit_count + 4'd1;
                n_bytes_left = r_bytes_left - 4'd1;
                fin          = (n_bytes_left == 4'd0);
            end
            PH_OPCODE: begin
                n_phase = PH_OPCODE;
                if (is_prefix(i_code_byte)) begin
                    if (cur_tally >= r_max_prefixes) begin
                        emit    = 1'b1;
                        e_kind  = KIND_ERROR;
                        n_tally = 4'd0;
                        n_osz   = 1'b0;
                    end else begin
                        n_tally = cur_tally + 4'd1;
                        if (i_code_byte == 8'h66) begin
                            n_osz = 1'b1;
                        end
                        if (i_code_byte == 8'h0F) begin
                            n_phase = PH_ESCAPE;
                        end else begin
                            emit = 1'b1;
                        end
                    end
                end else if (i_code_byte >= 8'h6C && i_code_byte <= 8'h6F) begin
                    emit    = 1'b1;
                    e_kind  = KIND_ERROR;
                    n_tally = 4'd0;
                    n_osz   = 1'b0;
                end else begin
                    n_held       = i_code_byte;
                    n_unit_count = 4'd1;
                    n_modrm_seen = 1'b0;
                    n_sib_seen   = 1'b0;
                    n_imm        = imm_bytes(i_code_byte, cur_osz);
                    if (takes_modrm(i_code_byte)) begin
                        n_phase = PH_MODRM;
                    end else begin
                        hdr = 1'b1;
                    end
                end
            end
            default: n_phase = PH_OPCODE;
        endcase

        if (hdr) begin
            hdr_total = {1'b0, hdr_disp} + {1'b0, n_imm};
            if (hdr_total == 4'd0) begin
                fin = 1'b1;
            end else begin
                n_bytes_left = hdr_total;
                n_phase      = PH_TAIL;
            end
        end

        if (fin) begin
            emit    = 1'b1;
            e_len   = n_unit_count;
            e_kind  = KIND_INSN;
            e_op    = n_held;
            e_mr    = n_modrm_seen;
            e_opb   = n_unit_count - 4'd1 - {3'b000, n_modrm_seen} - {3'b000, n_sib_seen};
            e_pb    = n_tally;
            n_tally = 4'd0;
            n_osz   = 1'b0;
            n_phase = PH_OPCODE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_prefixes <= MAX_PREFIXES_RST;
            r_phase        <= PH_OPCODE;
            r_bytes_left   <= 4'd0;
            r_imm          <= 3'd0;
            r_unit_count   <= 4'd0;
            r_tally        <= 4'd0;
            r_osz          <= 1'b0;
            r_held         <= 8'd0;
            r_modrm_seen   <= 1'b0;
            r_sib_seen     <= 1'b0;
            r_offset       <= '0;
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_max_prefixes <= i_cfg_data;
            end
            if (in_fire) begin
                r_phase      <= n_phase;
                r_bytes_left <= n_bytes_left;
                r_imm        <= n_imm;
                r_unit_count <= n_unit_count;
                r_tally      <= n_tally;
                r_osz        <= n_osz;
                r_held       <= n_held;
                r_modrm_seen <= n_modrm_seen;
                r_sib_seen   <= n_sib_seen;
                r_offset     <= n_offset;
            end
            if (o_in_ready) begin
                r_out_valid <= in_fire && emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire && emit) begin
            r_len        <= e_len;
            r_kind       <= e_kind;
            r_op         <= e_op;
            r_mr         <= e_mr;
            r_opb        <= e_opb;
            r_pb         <= e_pb;
            r_out_offset <= 32'(n_offset);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_unit_length     = r_len;
    assign o_unit_kind       = r_kind;
    assign o_opcode_value    = r_op;
    assign o_has_modrm       = r_mr;
    assign o_operand_bytes   = r_opb;
    assign o_prefixes_before = r_pb;
    assign o_running_offset  = r_out_offset;

    `ILD_ASSERT_NOW(a_len_range, r_out_valid, r_len >= 4'd1 && r_len <= 4'd11, "unit length out of range")
    `ILD_ASSERT_NOW(a_single_byte, r_out_valid && (r_kind == KIND_PREFIX || r_kind == KIND_ERROR), r_len == 4'd1 && !r_mr && r_opb == 4'd0, "prefix or error unit malformed")
    `ILD_ASSERT_NOW(a_escape_pair, r_out_valid && r_kind == KIND_ESCAPE, r_len == 4'd2 && !r_mr && r_opb == 4'd0, "escape unit malformed")
    `ILD_ASSERT_NEXT(a_restart_offset, in_fire && i_restart, r_offset == OFFSET_BITS'(1), "offset not restarted")

endmodule

### tb/tb_x86_instruction_length_decoder.sv
`timescale 1ns / 100ps
// Self-checking testbench for x86_instruction_length_decoder: byte-serial code
// stream in, decoded units out, each checked against an in-bench length predictor.
// Depends on x86ild_pkg and the decoder RTL.
module tb_x86_instruction_length_decoder
    import x86ild_pkg::*;
();

    localparam int unsigned TIMEOUT_NS    = 10_000_000;
    localparam int          DRAIN_LIMIT   = 5000;
    localparam int          SETTLE_CYCLES = 4;
    localparam int          MAX_REPORTS   = 100;

    localparam logic [7:0] OP_ESCAPE    = 8'h0F;
    localparam logic [7:0] OP_OPSIZE    = 8'h66;
    localparam logic [7:0] OP_GRP3_B    = 8'hF6;
    localparam logic [7:0] OP_GRP3_V    = 8'hF7;
    localparam logic [7:0] OP_NOP       = 8'h90;
    localparam logic [7:0] OP_BAD_FIRST = 8'h6C;
    localparam logic [7:0] OP_BAD_LAST  = 8'h6F;
    localparam logic [2:0] RM_DISP32    = 3'd5;
    localparam logic [2:0] RM_SIB       = 3'd4;
    localparam logic [2:0] BASE_DISP32  = 3'd5;

    // escape byte last so random picks can leave it out
    localparam logic [7:0] PREFIX_BYTES [12] = '{8'h26, 8'h2E, 8'h36, 8'h3E, 8'h64, 8'h65,
                                                 8'h66, 8'h67, 8'hF0, 8'hF2, 8'hF3, 8'h0F};
    localparam logic [7:0] MODRM_OPS [10] = '{8'h62, 8'h63, 8'h69, 8'h6B, 8'hC0, 8'hC1,
                                              8'hF6, 8'hF7, 8'hFE, 8'hFF};
    localparam logic [7:0] IB_OPS [13] = '{8'h6A, 8'h6B, 8'h80, 8'h82, 8'h83, 8'hA8, 8'hC0,
                                           8'hC1, 8'hC6, 8'hCD, 8'hD4, 8'hD5, 8'hEB};
    localparam logic [7:0] IZ_OPS [7] = '{8'h68, 8'h69, 8'h81, 8'hA9, 8'hC7, 8'hE8, 8'hE9};

    // bit 8 = restart
    localparam logic [8:0] DIRECTED_BEATS [23] = '{
        9'h090,
        9'h000, 9'h0C0,
        9'h066, 9'h0F7, 9'h0C0, 9'h034, 9'h012,
        9'h00F, 9'h0FF,
        9'h06E,
        9'h026, 9'h02E, 9'h036, 9'h03E, 9'h064,
        9'h081, 9'h080, 9'h1C3,
        9'h08B, 9'h044, 9'h024, 9'h008
    };

    typedef enum logic [2:0] {
        IMM_NONE, IMM_BYTE, IMM_WORD, IMM_ZV, IMM_ENTER, IMM_FARPTR, IMM_MOFFS
    } t_imm_size;

    typedef struct packed {
        logic [3:0]  len;
        logic [1:0]  kind;
        logic [7:0]  opcode;
        logic        modrm;
        logic [3:0]  opnd;
        logic [3:0]  npfx;
        logic [31:0] offset;
    } t_unit;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_code_byte;
    logic        i_restart;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [3:0]  o_unit_length;
    logic [1:0]  o_unit_kind;
    logic [7:0]  o_opcode_value;
    logic        o_has_modrm;
    logic [3:0]  o_operand_bytes;
    logic [3:0]  o_prefixes_before;
    logic [31:0] o_running_offset;

    x86_instruction_length_decoder u_dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_in_valid),
        .o_in_ready        (o_in_ready),
        .i_code_byte       (i_code_byte),
        .i_restart         (i_restart),
        .o_out_valid       (o_out_valid),
        .i_out_ready       (i_out_ready),
        .o_unit_length     (o_unit_length),
        .o_unit_kind       (o_unit_kind),
        .o_opcode_value    (o_opcode_value),
        .o_has_modrm       (o_has_modrm),
        .o_operand_bytes   (o_operand_bytes),
        .o_prefixes_before (o_prefixes_before),
        .o_running_offset  (o_running_offset)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // opcode tables
    logic      is_pfx_tab [256];
    logic      modrm_tab  [256];
    t_imm_size imm_tab    [256];

    // predictor state
    t_phase      ild_phase;
    logic [3:0]  left_cnt;
    logic [2:0]  imm_pend;
    logic [3:0]  unit_len;
    logic [3:0]  pfx_cnt;
    logic [3:0]  pfx_limit;
    logic        osz_seen;
    logic [7:0]  cur_op;
    logic        got_modrm;
    logic        got_sib;
    logic [31:0] ild_offset;

    t_unit pending_units [$];
    t_unit want_u;
    t_unit got_u;

    int  n_fail      = 0;
    int  beats_sent  = 0;
    bit  idle_on     = 1'b0;
    int  hold_cycles = 0;

    initial begin
        for (int k = 0; k < 256; k++) begin
            is_pfx_tab[k] = 1'b0;
            modrm_tab[k]  = (k < 8'h40) && (k % 8 < 4);
            imm_tab[k]    = IMM_NONE;
            if (k < 8'h40 && k % 8 == 4) imm_tab[k] = IMM_BYTE;
            if (k < 8'h40 && k % 8 == 5) imm_tab[k] = IMM_ZV;
            if ((k >= 8'h80 && k <= 8'h8F) || (k >= 8'hC4 && k <= 8'hC7)
                || (k >= 8'hD0 && k <= 8'hD3) || (k >= 8'hD8 && k <= 8'hDF)) modrm_tab[k] = 1'b1;
            if ((k >= 8'h70 && k <= 8'h7F) || (k >= 8'hB0 && k <= 8'hB7)
                || (k >= 8'hE0 && k <= 8'hE7)) imm_tab[k] = IMM_BYTE;
            if (k >= 8'hA0 && k <= 8'hA3) imm_tab[k] = IMM_MOFFS;
            if (k >= 8'hB8 && k <= 8'hBF) imm_tab[k] = IMM_ZV;
        end
        foreach (PREFIX_BYTES[k]) is_pfx_tab[PREFIX_BYTES[k]] = 1'b1;
        foreach (MODRM_OPS[k]) modrm_tab[MODRM_OPS[k]] = 1'b1;
        foreach (IB_OPS[k]) imm_tab[IB_OPS[k]] = IMM_BYTE;
        foreach (IZ_OPS[k]) imm_tab[IZ_OPS[k]] = IMM_ZV;
        imm_tab[8'hC2] = IMM_WORD;
        imm_tab[8'hCA] = IMM_WORD;
        imm_tab[8'hC8] = IMM_ENTER;
        imm_tab[8'h9A] = IMM_FARPTR;
        imm_tab[8'hEA] = IMM_FARPTR;
    end

    function automatic logic [2:0] imm_len(input t_imm_size c, input logic osz);
        case (c)
            IMM_BYTE:   return 3'd1;
            IMM_WORD:   return 3'd2;
            IMM_ENTER:  return 3'd3;
            IMM_MOFFS:  return 3'd4;
            IMM_ZV:     return osz ? 3'd2 : 3'd4;
            IMM_FARPTR: return osz ? 3'd4 : 3'd6;
            default:    return 3'd0;
        endcase
    endfunction

    task automatic reset_predictor();
        ild_phase  = PH_OPCODE;
        left_cnt   = '0;
        imm_pend   = '0;
        unit_len   = '0;
        pfx_cnt    = '0;
        pfx_limit  = MAX_PREFIXES_RST;
        osz_seen   = 1'b0;
        cur_op     = '0;
        got_modrm  = 1'b0;
        got_sib    = 1'b0;
        ild_offset = '0;
    endtask

    task automatic push_unit(input logic [3:0] len, input logic [1:0] kind,
                             input logic [7:0] opc, input logic mr,
                             input logic [3:0] opnd, input logic [3:0] npfx);
        pending_units.push_back('{len, kind, opc, mr, opnd, npfx, ild_offset});
    endtask

    task automatic finish_insn();
        push_unit(unit_len, KIND_INSN, cur_op, got_modrm,
                  unit_len - 4'd1 - {3'b0, got_modrm} - {3'b0, got_sib}, pfx_cnt);
        pfx_cnt   = '0;
        osz_seen  = 1'b0;
        ild_phase = PH_OPCODE;
    endtask

    task automatic close_header(input logic [3:0] dsp);
        logic [3:0] total;
        total = dsp + {1'b0, imm_pend};
        if (total == 4'd0) begin
            finish_insn();
        end else begin
            left_cnt  = total;
            ild_phase = PH_TAIL;
        end
    endtask

    task automatic error_unit(input logic [7:0] b);
        push_unit(4'd1, KIND_ERROR, b, 1'b0, 4'd0, pfx_cnt);
        pfx_cnt   = '0;
        osz_seen  = 1'b0;
        ild_phase = PH_OPCODE;
    endtask

    // advance the length decode by one accepted byte
    task automatic decode_length(input logic [7:0] b, input logic rs);
        logic [1:0] md;
        logic [2:0] rg;
        logic [2:0] rmf;
        logic [3:0] dsp;
        logic [3:0] pfx_prior;
        md  = b[7:6];
        rg  = b[5:3];
        rmf = b[2:0];
        if (rs) begin
            ild_offset = '0;
            pfx_cnt    = '0;
            osz_seen   = 1'b0;
            ild_phase  = PH_OPCODE;
        end
        ild_offset = ild_offset + 32'd1;
        case (ild_phase)
            PH_ESCAPE: begin
                ild_phase = PH_OPCODE;
                push_unit(4'd2, KIND_ESCAPE, b, 1'b0, 4'd0, pfx_cnt - 4'd1);
            end
            PH_MODRM: begin
                unit_len  = unit_len + 4'd1;
                got_modrm = 1'b1;
                if ((cur_op == OP_GRP3_B || cur_op == OP_GRP3_V) && rg == 3'd0)
                    imm_pend = (cur_op == OP_GRP3_B) ? 3'd1 : (osz_seen ? 3'd2 : 3'd4);
                case (md)
                    2'd3:    dsp = 4'd0;
                    2'd1:    dsp = 4'd1;
                    2'd2:    dsp = 4'd4;
                    default: dsp = (rmf == RM_DISP32) ? 4'd4 : 4'd0;
                endcase
                if (md != 2'd3 && rmf == RM_SIB) begin
                    left_cnt  = dsp;
                    ild_phase = (md == 2'd0) ? PH_SIB_MOD0 : PH_SIB;
                end else begin
                    close_header(dsp);
                end
            end
            PH_SIB, PH_SIB_MOD0: begin
                unit_len = unit_len + 4'd1;
                got_sib  = 1'b1;
                dsp      = left_cnt;
                if (ild_phase == PH_SIB_MOD0 && rmf == BASE_DISP32) dsp = 4'd4;
                close_header(dsp);
            end
            PH_TAIL: begin
                unit_len = unit_len + 4'd1;
                left_cnt = left_cnt - 4'd1;
                if (left_cnt == 4'd0) finish_insn();
            end
            default: begin
                ild_phase = PH_OPCODE;
                if (is_pfx_tab[b]) begin
                    if (pfx_cnt >= pfx_limit) begin
                        error_unit(b);
                    end else begin
                        pfx_prior = pfx_cnt;
                        pfx_cnt   = pfx_cnt + 4'd1;
                        if (b == OP_OPSIZE) osz_seen = 1'b1;
                        if (b == OP_ESCAPE) ild_phase = PH_ESCAPE;
                        else push_unit(4'd1, KIND_PREFIX, b, 1'b0, 4'd0, pfx_prior);
                    end
                end else if (b >= OP_BAD_FIRST && b <= OP_BAD_LAST) begin
                    error_unit(b);
                end else begin
                    cur_op    = b;
                    unit_len  = 4'd1;
                    got_modrm = 1'b0;
                    got_sib   = 1'b0;
                    imm_pend  = imm_len(imm_tab[b], osz_seen);
                    if (modrm_tab[b]) ild_phase = PH_MODRM;
                    else close_header(4'd0);
                end
            end
        endcase
    endtask

    task automatic report_mismatch(input string field, input longint unsigned want,
                                   input longint unsigned got);
        n_fail++;
        if (n_fail <= MAX_REPORTS)
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            got_u = {o_unit_length, o_unit_kind, o_opcode_value, o_has_modrm,
                     o_operand_bytes, o_prefixes_before, o_running_offset};
            if (pending_units.size() == 0) begin
                report_mismatch("unexpected unit", 0, got_u);
            end else begin
                want_u = pending_units.pop_front();
                if (got_u.len !== want_u.len)
                    report_mismatch("unit_length", want_u.len, got_u.len);
                if (got_u.kind !== want_u.kind)
                    report_mismatch("unit_kind", want_u.kind, got_u.kind);
                if (got_u.opcode !== want_u.opcode)
                    report_mismatch("opcode_value", want_u.opcode, got_u.opcode);
                if (got_u.modrm !== want_u.modrm)
                    report_mismatch("has_modrm", want_u.modrm, got_u.modrm);
                if (got_u.opnd !== want_u.opnd)
                    report_mismatch("operand_bytes", want_u.opnd, got_u.opnd);
                if (got_u.npfx !== want_u.npfx)
                    report_mismatch("prefixes_before", want_u.npfx, got_u.npfx);
                if (got_u.offset !== want_u.offset)
                    report_mismatch("running_offset", want_u.offset, got_u.offset);
            end
        end
    end

    // output side: random stalls, plus a long hold-off on request
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_cycles != 0) begin
                i_out_ready = 1'b0;
                repeat (hold_cycles - 1) @(negedge i_clk);
                hold_cycles = 0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_ready = 1'b0;
                repeat ($urandom_range(0, 11)) @(negedge i_clk);
            end else begin
                i_out_ready = 1'b1;
            end
        end
    end

    task automatic send_beat(input logic [7:0] b, input logic rs);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            @(negedge i_clk);
            i_in_valid = 1'b0;
            repeat ($urandom_range(0, 11)) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid  = 1'b1;
        i_code_byte = b;
        i_restart   = rs;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        decode_length(b, rs);
        beats_sent++;
    endtask

    task automatic wait_drained();
        int guard;
        guard = 0;
        @(negedge i_clk);
        i_in_valid = 1'b0;
        i_restart  = 1'b0;
        while (pending_units.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_max_prefixes(input logic [3:0] v);
        wait_drained();
        @(negedge i_clk);
        i_cfg_we   = 1'b1;
        i_cfg_data = v;
        @(posedge i_clk);
        pfx_limit = v;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    // prefixes, opcode, then whatever bytes the decode still wants
    task automatic send_insn();
        int         n_pfx;
        logic [7:0] op;
        if ($urandom_range(0, 3) == 0) n_pfx = $urandom_range(0, int'(pfx_limit) + 1);
        else n_pfx = $urandom_range(0, 2);
        repeat (n_pfx) begin
            if ($urandom_range(0, 7) == 0) send_beat(OP_ESCAPE, 1'b0);
            else send_beat(PREFIX_BYTES[$urandom_range(0, 10)], 1'b0);
        end
        op = 8'($urandom_range(0, 255));
        if ($urandom_range(0, 15) == 0) op = OP_BAD_FIRST + 8'($urandom_range(0, 3));
        send_beat(op, $urandom_range(0, 31) == 0);
        while (ild_phase != PH_OPCODE)
            send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 127) == 0);
    endtask

    task automatic test_directed();
        idle_on = 1'b0;
        foreach (DIRECTED_BEATS[k]) send_beat(DIRECTED_BEATS[k][7:0], DIRECTED_BEATS[k][8]);
    endtask

    task automatic test_random_stream(input int n_beats, input logic [3:0] limit);
        int stop_at;
        set_max_prefixes(limit);
        stop_at = beats_sent + n_beats;
        idle_on = 1'b1;
        while (beats_sent < stop_at) begin
            if ($urandom_range(0, 63) == 0) idle_on = !idle_on;
            if ($urandom_range(0, 9) == 0)
                send_beat(8'($urandom_range(0, 255)), $urandom_range(0, 15) == 0);
            else
                send_insn();
        end
    endtask

    // receiver holds off while bytes keep coming, then the sender waits for all units
    task automatic test_output_stall();
        wait_drained();
        idle_on     = 1'b0;
        hold_cycles = 80;
        repeat (40) begin
            if ($urandom_range(0, 1) == 1) send_beat(PREFIX_BYTES[$urandom_range(0, 10)], 1'b0);
            else send_beat(OP_NOP, 1'b0);
        end
        wait_drained();
    endtask

    task automatic test_full_rate(input int n_beats);
        int stop_at;
        set_max_prefixes(MAX_PREFIXES_RST);
        idle_on = 1'b0;
        stop_at = beats_sent + n_beats;
        while (beats_sent < stop_at) send_insn();
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_data  = '0;
        i_in_valid  = 1'b0;
        i_code_byte = '0;
        i_restart   = 1'b0;
        reset_predictor();
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random_stream(350, 4'd1);
        test_random_stream(350, 4'd15);
        test_random_stream(250, 4'($urandom_range(2, 14)));
        test_output_stall();
        test_full_rate(340);

        wait_drained();
        if (pending_units.size() != 0) begin
            n_fail++;
            $display("%0t: %0d units expected but never seen", $time, pending_units.size());
        end
        if (n_fail == 0)
            $display("tb_x86_instruction_length_decoder OK");
        else
            $display("tb_x86_instruction_length_decoder NOT OK");
        $finish;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_x86_instruction_length_decoder NOT OK");
        $finish;
    end

endmodule

### sim.f
+incdir+src
src/x86ild_pkg.sv
src/x86_instruction_length_decoder.sv
tb/tb_x86_instruction_length_decoder.sv
